[rtl/core/nps_pkg.sv]
// Package for the nearest point search unit: field widths, command and
// status codes, controller states and the structs passed between the blocks.
// No dependencies.
package nps_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned MAX_DIMS_DEF   = 8;
  localparam int unsigned DIMS_RESET     = 2;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIMS_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned SQ_W     = 35;
  localparam int unsigned DIST_W   = 18;

  // wide enough for a point number at the largest supported point count
  localparam int unsigned PT_IDX_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_ADD_REF   = 2'd1,
    CMD_ADD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_ROOT
  } state_t;

  // one store read issued by the scan controller
  typedef struct packed {
    logic                      valid;
    logic                      last_dim;
    logic                      last_point;
    logic [PT_IDX_W-1:0]       point;
    logic signed [COORD_W-1:0] query;
  } scan_tag_t;

  // end of a scan and the winning point number
  typedef struct packed {
    logic                done;
    logic [PT_IDX_W-1:0] point;
  } min_tag_t;

endpackage

[rtl/core/nps_ifs.sv]
// Valid/ready channel interfaces for the nearest point search unit:
// the command channel and the result channel. Depends on nps_pkg.
interface nps_item_if import nps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] coordinate_value;

  modport source (output valid, command, coordinate_value, input ready);
  modport sink (input valid, command, coordinate_value, output ready);
endinterface

interface nps_result_if import nps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  nearest_index;
  logic [SQ_W-1:0]     squared_distance;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, status, nearest_index, squared_distance, distance,
                  input ready);
  modport sink (input valid, status, nearest_index, squared_distance, distance,
                output ready);
endinterface

[rtl/core/nps_store.sv]
// Reference point store: synchronous single-write, single-read memory with
// a registered read, plus the load address pointer. Depends on nps_pkg.
module nps_store import nps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_DIMS   = MAX_DIMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                we,
  input  logic                                point_done,
  input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] wcoord,
  input  logic [COORD_W-1:0]                  wdata,
  input  logic [(MAX_POINTS*MAX_DIMS > 1 ? $clog2(MAX_POINTS*MAX_DIMS) : 1)-1:0] raddr,
  output logic [COORD_W-1:0]                  rdata
);

  localparam int unsigned DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [COORD_W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]      load_base;
  logic [AW-1:0]      waddr;

  assign waddr = load_base + AW'(wcoord);

  // base of the point being loaded; steps one row per completed point
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
    end else if (clear) begin
      load_base <= '0;
    end else if (we && point_done) begin
      load_base <= load_base + AW'(MAX_DIMS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/nps_dist.sv]
// Distance pipeline: difference, square, per-point accumulate and running
// minimum over the store read stream. Depends on nps_pkg.
module nps_dist import nps_pkg::*; #(
  parameter int unsigned ACC_W = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  scan_tag_t          issue,
  input  logic [COORD_W-1:0] ref_coord,
  output min_tag_t           min_out,
  output logic [ACC_W-1:0]   best_sum
);

  scan_tag_t           s1_tag;
  scan_tag_t           s2_tag;
  scan_tag_t           s3_tag;
  logic [COORD_W-1:0]  s2_abs;
  logic [2*COORD_W-1:0] s3_sq;
  logic [ACC_W-1:0]    sum_acc;
  logic                first_dim;
  logic                s4_valid;
  logic                s4_last_point;
  logic [PT_IDX_W-1:0] s4_point;
  logic                have_best;
  logic                done;
  logic [PT_IDX_W-1:0] best_point;
  logic [COORD_W:0]    diff;
  logic [COORD_W:0]    diff_abs;

  assign diff     = {ref_coord[COORD_W-1], ref_coord}
                  - {s1_tag.query[COORD_W-1], s1_tag.query};
  assign diff_abs = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag    <= '0;
      s2_tag    <= '0;
      s3_tag    <= '0;
      s4_valid  <= 1'b0;
      first_dim <= 1'b1;
      have_best <= 1'b0;
      done      <= 1'b0;
    end else begin
      s1_tag   <= issue;
      s2_tag   <= s1_tag;
      s3_tag   <= s2_tag;
      s4_valid <= s3_tag.valid && s3_tag.last_dim;
      done     <= s4_valid && s4_last_point;
      if (s3_tag.valid) begin
        first_dim <= s3_tag.last_dim;
      end
      if (s4_valid) begin
        // drop the running minimum once the last point is compared
        have_best <= !s4_last_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_abs <= diff_abs[COORD_W-1:0];
    s3_sq  <= s2_abs * s2_abs;
    if (s3_tag.valid) begin
      sum_acc <= first_dim ? ACC_W'(s3_sq) : sum_acc + ACC_W'(s3_sq);
    end
    s4_last_point <= s3_tag.last_point;
    s4_point      <= s3_tag.point;
    // strict less-than keeps the first point on ties
    if (s4_valid && (!have_best || sum_acc < best_sum)) begin
      best_sum   <= sum_acc;
      best_point <= s4_point;
    end
  end

  assign min_out.done  = done;
  assign min_out.point = best_point;

endmodule

[rtl/core/nps_isqrt.sv]
// Floor integer square root, restoring digit method, one result bit per
// cycle. Depends on nps_pkg.
module nps_isqrt import nps_pkg::*; #(
  parameter int unsigned W = 35
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         value,
  output logic                 done,
  output logic [(W+1)/2-1:0]   root
);

  localparam int unsigned N  = (W + 1) / 2;
  localparam int unsigned VW = 2 * N;
  localparam int unsigned RW = 2 * N + 1;
  localparam int unsigned CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [RW-1:0] res;
  logic [RW-1:0] bitm;
  logic [RW-1:0] trial;

  assign trial = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= VW'(value);
      res  <= '0;
      bitm <= RW'(1) << (VW - 2);
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= VW'({1'b0, rem} - trial);
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root = res[N-1:0];

endmodule

[rtl/core/nearest_point_search_unit.sv]
// Nearest point search unit, top level: command decode, query buffer,
// scan sequencer and result buffering. Depends on nps_pkg, nps_ifs,
// nps_store, nps_dist and nps_isqrt.
//
//   channel   dir  handshake     payload
//   item      in   valid/ready   command, coordinate_value
//   result    out  valid/ready   status, nearest_index, squared_distance, distance
//   cfg       in   cfg_we        cfg_wdata (dims_in_use)
//
// Clear, reference and non-final query coordinates leave the unit idle.
// A final query coordinate over P stored points of D coordinates starts
// P*D store reads (one read port, one coordinate a cycle); then the
// distance pipeline drains, the square root runs and the result passes
// through the result buffer.
// Reset is synchronous; the store is not cleared and needs no sweep.
// Results go through a two-entry buffer; item ready drops while a query
// runs or while a result waits in the input-side entry.
module nearest_point_search_unit import nps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_DIMS   = MAX_DIMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  nps_item_if.sink          item,
  nps_result_if.source      result,
  input  logic              cfg_we,
  input  logic [DIMS_W-1:0] cfg_wdata
);

  localparam int unsigned DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned PC_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DE_W  = $clog2(MAX_DIMS + 1);
  localparam int unsigned DC_W  = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned ACC_W = 32 + $clog2(MAX_DIMS);
  localparam int unsigned RT_W  = (ACC_W + 1) / 2;
  localparam int unsigned DE1_W = DE_W + 1;
  localparam int unsigned PC1_W = PC_W + 1;

  state_t             state;
  state_t             state_next;
  logic [DIMS_W-1:0]  dims;
  logic [PC_W-1:0]    point_count;
  logic [DE_W-1:0]    load_cnt;
  logic [DE_W-1:0]    query_cnt;
  logic [COORD_W-1:0] qbuf [0:MAX_DIMS-1];
  logic [PC_W-1:0]    scan_point;
  logic [DE_W-1:0]    scan_dim;
  logic [AW-1:0]      scan_base;

  logic [4:0]         dims_wide;
  logic [4:0]         eff_wide;
  logic [DE_W-1:0]    eff_dims;

  logic               rdy;
  logic               accept;
  cmd_t               cmd;
  logic               full;
  logic               ref_last;
  logic               query_last;
  logic               store_we;

  scan_tag_t          issue;
  logic [AW-1:0]      raddr;
  logic [COORD_W-1:0] rdata;
  min_tag_t           min_out;
  logic [ACC_W-1:0]   best_sum;
  logic               sqrt_start;
  logic               root_done;
  logic [RT_W-1:0]    root;

  logic               pend_load;
  status_t            pend_status_next;
  logic               pend_valid;
  status_t            pend_status;
  logic [INDEX_W-1:0] pend_index;
  logic [SQ_W-1:0]    pend_sq;
  logic [DIST_W-1:0]  pend_dist;
  logic               pend_move;
  logic               out_valid;
  status_t            out_status;
  logic [INDEX_W-1:0] out_index;
  logic [SQ_W-1:0]    out_sq;
  logic [DIST_W-1:0]  out_dist;

  // dims of zero act as one, above the capacity as the capacity
  assign dims_wide = {1'b0, dims};
  always_comb begin
    if (dims_wide == 5'd0) begin
      eff_wide = 5'd1;
    end else if (dims_wide > 5'(MAX_DIMS)) begin
      eff_wide = 5'(MAX_DIMS);
    end else begin
      eff_wide = dims_wide;
    end
  end
  assign eff_dims = DE_W'(eff_wide);

  assign rdy        = (state == S_IDLE) && !pend_valid;
  assign item.ready = rdy;
  assign accept     = item.valid && rdy;
  assign cmd        = cmd_t'(item.command);
  assign full       = point_count >= PC_W'(MAX_POINTS);
  assign ref_last   = (DE1_W'(load_cnt) + DE1_W'(1)) >= DE1_W'(eff_dims);
  assign query_last = (DE1_W'(query_cnt) + DE1_W'(1)) >= DE1_W'(eff_dims);
  assign store_we   = accept && (cmd == CMD_ADD_REF) && !full;

  assign raddr = scan_base + AW'(scan_dim);

  always_comb begin
    state_next       = state;
    issue            = '0;
    pend_load        = 1'b0;
    pend_status_next = ST_FOUND;
    sqrt_start       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_ADD_REF && full) begin
          pend_load        = 1'b1;
          pend_status_next = ST_FULL;
        end
        if (accept && cmd == CMD_ADD_QUERY && query_last) begin
          if (point_count == '0) begin
            pend_load        = 1'b1;
            pend_status_next = ST_EMPTY;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue.valid      = 1'b1;
        issue.last_dim   = (DE1_W'(scan_dim) + DE1_W'(1)) >= DE1_W'(eff_dims);
        issue.last_point = (PC1_W'(scan_point) + PC1_W'(1)) >= PC1_W'(point_count);
        issue.point      = PT_IDX_W'(scan_point);
        issue.query      = qbuf[scan_dim[DC_W-1:0]];
        if (issue.last_dim && issue.last_point) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (min_out.done) begin
          sqrt_start = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          pend_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign pend_move = pend_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dims        <= DIMS_W'(DIMS_RESET);
      point_count <= '0;
      load_cnt    <= '0;
      query_cnt   <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        dims <= cfg_wdata;
      end
      if (accept) begin
        unique case (cmd)
          CMD_CLEAR: begin
            point_count <= '0;
            load_cnt    <= '0;
          end
          CMD_ADD_REF: begin
            if (!full) begin
              if (ref_last) begin
                load_cnt    <= '0;
                point_count <= point_count + 1'b1;
              end else begin
                load_cnt <= load_cnt + 1'b1;
              end
            end
          end
          CMD_ADD_QUERY: begin
            query_cnt <= query_last ? '0 : query_cnt + 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_ADD_QUERY) begin
      qbuf[query_cnt[DC_W-1:0]] <= item.coordinate_value;
    end
    if (state == S_IDLE) begin
      scan_point <= '0;
      scan_dim   <= '0;
      scan_base  <= '0;
    end else if (state == S_SCAN) begin
      // advance one coordinate, wrap to the next row at the point end
      if (issue.last_dim) begin
        scan_dim   <= '0;
        scan_point <= scan_point + 1'b1;
        scan_base  <= scan_base + AW'(MAX_DIMS);
      end else begin
        scan_dim <= scan_dim + 1'b1;
      end
    end
    if (pend_load) begin
      pend_status <= pend_status_next;
      if (pend_status_next == ST_FOUND) begin
        pend_index <= INDEX_W'(32'(min_out.point) + 32'd1);
        pend_sq    <= SQ_W'(best_sum);
        pend_dist  <= DIST_W'(root);
      end else begin
        pend_index <= '0;
        pend_sq    <= '0;
        pend_dist  <= '0;
      end
    end
    if (pend_move) begin
      out_status <= pend_status;
      out_index  <= pend_index;
      out_sq     <= pend_sq;
      out_dist   <= pend_dist;
    end
  end

  assign result.valid            = out_valid;
  assign result.status           = out_status;
  assign result.nearest_index    = out_index;
  assign result.squared_distance = out_sq;
  assign result.distance         = out_dist;

  nps_store #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept && cmd == CMD_CLEAR),
    .we         (store_we),
    .point_done (ref_last),
    .wcoord     (load_cnt[DC_W-1:0]),
    .wdata      (item.coordinate_value),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  nps_dist #(
    .ACC_W (ACC_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .ref_coord (rdata),
    .min_out   (min_out),
    .best_sum  (best_sum)
  );

  nps_isqrt #(
    .W (ACC_W)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (best_sum),
    .done  (root_done),
    .root  (root)
  );

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (point_count != '0))
    else $error("scan running with an empty store");

  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pend_valid)
    else $error("result waiting while a query is in flight");

  assert property (@(posedge clk) disable iff (rst)
    point_count <= PC_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    min_out.done |-> (state == S_WAIT))
    else $error("minimum search finished outside the wait state");

  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_FOUND) |->
      (result.squared_distance == '0 && result.distance == '0))
    else $error("non-found result carries a distance");

endmodule
